[design/rrr_pkg.sv]
`default_nettype none
package rrr_pkg;

  localparam int FIELD_W = 16;
  localparam int COMP_FRAC_BITS_DEF = 14;
  localparam int INDEX_FRAC_BITS_DEF = 12;

  typedef struct packed {
    logic signed [FIELD_W-1:0] dir_x;
    logic signed [FIELD_W-1:0] dir_y;
    logic signed [FIELD_W-1:0] dir_z;
    logic signed [FIELD_W-1:0] norm_x;
    logic signed [FIELD_W-1:0] norm_y;
    logic signed [FIELD_W-1:0] norm_z;
    logic [FIELD_W-1:0]        index_ratio;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] refr_x;
    logic signed [FIELD_W-1:0] refr_y;
    logic signed [FIELD_W-1:0] refr_z;
    logic signed [FIELD_W-1:0] refl_x;
    logic signed [FIELD_W-1:0] refl_y;
    logic signed [FIELD_W-1:0] refl_z;
    logic                      total_reflection;
  } out_t;

  // clamp to [-2^f, 2^f], keep the low field bits
  function automatic logic [FIELD_W-1:0] sat_out(input logic signed [63:0] v,
                                                 input int f);
    logic signed [63:0] lim;
    logic signed [63:0] r;
    lim = 64'sd1 <<< f;
    r = v;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[FIELD_W-1:0];
  endfunction

endpackage
`default_nettype wire

[design/rrr_front.sv]
`default_nettype none
module rrr_front import rrr_pkg::*; #(
  parameter int COMP_FRAC_BITS = COMP_FRAC_BITS_DEF,
  parameter int INDEX_FRAC_BITS = INDEX_FRAC_BITS_DEF,
  localparam int F = COMP_FRAC_BITS,
  localparam int G = INDEX_FRAC_BITS,
  localparam int AW = 34 - G,
  localparam int KPW = 52 - G - F,
  localparam int XW = 2 * F + 2
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire in_t                     in_data,
  output logic                         f_valid,
  output logic [XW-1:0]                f_x,
  output logic [2:0][FIELD_W-1:0]      f_nv,
  output logic [2:0][AW-1:0]           f_a,
  output logic [KPW-1:0]               f_kp,
  output logic [2:0][FIELD_W-1:0]      f_refl,
  output logic                         f_tir
);

  localparam int DW = 34;
  localparam int DW1 = DW + 1;
  localparam int CW = DW1 - F;
  localparam int CCW = 2 * CW;
  localparam int RPW = DW + 17;
  localparam int RPW1 = RPW + 1;
  localparam int OM2W = ((CCW > 2 * F) ? CCW : 2 * F) + 2;
  localparam int SPW = 32 + F + 1;
  localparam int SPW1 = SPW + 1;

  localparam logic [OM2W-1:0] ONE2 = OM2W'(1) << (2 * F);
  localparam logic [F:0] ONE = (F + 1)'(1) << F;

  logic [5:0] v_r;

  // stage 1
  logic signed [FIELD_W-1:0] d1_r [3];
  logic signed [FIELD_W-1:0] nv1_r [3];
  logic [FIELD_W-1:0] n1_r;
  logic signed [31:0] pdn1_r [3];
  logic signed [32:0] pnd1_r [3];
  // stage 2
  logic signed [FIELD_W-1:0] d2_r [3];
  logic signed [FIELD_W-1:0] nv2_r [3];
  logic [FIELD_W-1:0] n2v_r;
  logic signed [DW-1:0] dot2_r;
  logic [31:0] nn2_r;
  logic signed [AW-1:0] a2_r [3];
  // stage 3
  logic signed [FIELD_W-1:0] d3_r [3];
  logic signed [FIELD_W-1:0] nv3_r [3];
  logic [31:0] nn3_r;
  logic signed [AW-1:0] a3_r [3];
  logic signed [CCW-1:0] cc3_r;
  logic signed [RPW-1:0] rp3_r [3];
  logic signed [RPW-1:0] np3_r;
  // stage 4
  logic signed [FIELD_W-1:0] nv4_r [3];
  logic [31:0] nn4_r;
  logic signed [AW-1:0] a4_r [3];
  logic [F:0] om4_r;
  logic [FIELD_W-1:0] refl4_r [3];
  logic signed [KPW-1:0] kp4_r;
  // stage 5
  logic signed [FIELD_W-1:0] nv5_r [3];
  logic signed [AW-1:0] a5_r [3];
  logic [FIELD_W-1:0] refl5_r [3];
  logic signed [KPW-1:0] kp5_r;
  logic [SPW-1:0] sp5_r;
  // stage 6
  logic signed [FIELD_W-1:0] nv6_r [3];
  logic signed [AW-1:0] a6_r [3];
  logic [FIELD_W-1:0] refl6_r [3];
  logic signed [KPW-1:0] kp6_r;
  logic [XW-1:0] x6_r;
  logic tir6_r;

  logic signed [FIELD_W-1:0] d_in [3];
  logic signed [FIELD_W-1:0] nv_in [3];
  logic signed [33:0] a_t [3];
  logic signed [DW1-1:0] c_t;
  logic signed [CW-1:0] c_w;
  logic signed [OM2W-1:0] om2_w;
  logic [OM2W-1:0] om_t;
  logic [F:0] om_w;
  logic signed [RPW1-1:0] rl_t [3];
  logic signed [RPW1-1:0] kp_t;
  logic [SPW1-1:0] s_t;
  logic [SPW1-1:0] s_w;
  logic tir_w;

  assign d_in[0] = in_data.dir_x;
  assign d_in[1] = in_data.dir_y;
  assign d_in[2] = in_data.dir_z;
  assign nv_in[0] = in_data.norm_x;
  assign nv_in[1] = in_data.norm_y;
  assign nv_in[2] = in_data.norm_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_t[i] = (34'(pnd1_r[i]) + (34'sd1 <<< (G - 1))) >>> G;
      rl_t[i] = (RPW1'(rp3_r[i]) + (RPW1'(1) <<< (2 * F - 1))) >>> (2 * F);
    end
    c_t = (DW1'(dot2_r) + (DW1'(1) <<< (F - 1))) >>> F;
    c_w = c_t[CW-1:0];
    om2_w = $signed(ONE2) - OM2W'(cc3_r);
    if (om2_w < 0) om2_w = '0;
    om_t = (OM2W'(om2_w) + (OM2W'(1) << (F - 1))) >> F;
    om_w = (om_t > OM2W'(ONE)) ? ONE : om_t[F:0];
    kp_t = (RPW1'(np3_r) + (RPW1'(1) <<< (G + F - 1))) >>> (G + F);
    s_t = (SPW1'(sp5_r) + (SPW1'(1) << (2 * G - 1))) >> (2 * G);
    s_w = s_t;
    tir_w = s_w > SPW1'(ONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], in_valid};
    end
    for (int i = 0; i < 3; i++) begin
      d1_r[i] <= d_in[i];
      nv1_r[i] <= nv_in[i];
      pdn1_r[i] <= 32'(d_in[i]) * 32'(nv_in[i]);
      pnd1_r[i] <= 33'($signed({1'b0, in_data.index_ratio})) * 33'(d_in[i]);
      d2_r[i] <= d1_r[i];
      nv2_r[i] <= nv1_r[i];
      a2_r[i] <= a_t[i][AW-1:0];
      d3_r[i] <= d2_r[i];
      nv3_r[i] <= nv2_r[i];
      a3_r[i] <= a2_r[i];
      rp3_r[i] <= (RPW'(dot2_r) * RPW'(nv2_r[i])) <<< 1;
      nv4_r[i] <= nv3_r[i];
      a4_r[i] <= a3_r[i];
      refl4_r[i] <= sat_out(64'(d3_r[i]) - 64'(rl_t[i]), F);
      nv5_r[i] <= nv4_r[i];
      a5_r[i] <= a4_r[i];
      refl5_r[i] <= refl4_r[i];
      nv6_r[i] <= nv5_r[i];
      a6_r[i] <= a5_r[i];
      refl6_r[i] <= refl5_r[i];
    end
    n1_r <= in_data.index_ratio;
    n2v_r <= n1_r;
    dot2_r <= DW'(pdn1_r[0]) + DW'(pdn1_r[1]) + DW'(pdn1_r[2]);
    nn2_r <= 32'(n1_r) * 32'(n1_r);
    nn3_r <= nn2_r;
    cc3_r <= CCW'(c_w) * CCW'(c_w);
    np3_r <= RPW'($signed({1'b0, n2v_r})) * RPW'(dot2_r);
    nn4_r <= nn3_r;
    om4_r <= om_w;
    kp4_r <= kp_t[KPW-1:0];
    kp5_r <= kp4_r;
    sp5_r <= SPW'(nn4_r) * SPW'(om4_r);
    kp6_r <= kp5_r;
    tir6_r <= tir_w;
    x6_r <= tir_w ? '0 : (XW'(ONE - s_w[F:0]) << F);
  end

  assign f_valid = v_r[5];
  assign f_x = x6_r;
  assign f_kp = kp6_r;
  assign f_tir = tir6_r;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_nv[i] = nv6_r[i];
      f_a[i] = a6_r[i];
      f_refl[i] = refl6_r[i];
    end
  end

endmodule
`default_nettype wire

[design/rrr_sqrt.sv]
`default_nettype none
module rrr_sqrt #(
  parameter int RW = 15,
  parameter int SW = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [2*RW-1:0] in_x,
  input  wire logic [SW-1:0]   in_side,
  output logic                 out_valid,
  output logic [RW-1:0]        out_root,
  output logic [SW-1:0]        out_side
);

  localparam int XW = 2 * RW;
  localparam int MW = RW + 2;

  logic [RW:1]     v_r;
  logic [XW-1:0]   x_r    [1:RW];
  logic [MW-1:0]   rem_r  [1:RW];
  logic [RW-1:0]   root_r [1:RW];
  logic [SW-1:0]   side_r [1:RW];
  logic            vq_r;
  logic [RW-1:0]   q_r;
  logic [SW-1:0]   sq_r;

  // one root bit per stage, restoring
  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic          v_in;
    logic [XW-1:0] x_in;
    logic [MW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [SW-1:0] side_in;
    logic [MW-1:0] rem_sh;
    logic [MW-1:0] trial;
    if (i == 0) begin : g_head
      assign v_in = in_valid;
      assign x_in = in_x;
      assign rem_in = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_body
      assign v_in = v_r[i];
      assign x_in = x_r[i];
      assign rem_in = rem_r[i];
      assign root_in = root_r[i];
      assign side_in = side_r[i];
    end
    assign rem_sh = {rem_in[MW-3:0], x_in[XW-1 -: 2]};
    assign trial = {root_in, 2'b01};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_in;
      end
      x_r[i+1] <= x_in << 2;
      side_r[i+1] <= side_in;
      if (rem_sh >= trial) begin
        rem_r[i+1] <= rem_sh - trial;
        root_r[i+1] <= {root_in[RW-2:0], 1'b1};
      end else begin
        rem_r[i+1] <= rem_sh;
        root_r[i+1] <= {root_in[RW-2:0], 1'b0};
      end
    end
  end

  // round to nearest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
    end else begin
      vq_r <= v_r[RW];
    end
    q_r <= root_r[RW] + RW'(rem_r[RW] > MW'(root_r[RW]));
    sq_r <= side_r[RW];
  end

  assign out_valid = vq_r;
  assign out_root = q_r;
  assign out_side = sq_r;

endmodule
`default_nettype wire

[design/rrr_back.sv]
`default_nettype none
module rrr_back import rrr_pkg::*; #(
  parameter int COMP_FRAC_BITS = COMP_FRAC_BITS_DEF,
  parameter int INDEX_FRAC_BITS = INDEX_FRAC_BITS_DEF,
  localparam int F = COMP_FRAC_BITS,
  localparam int G = INDEX_FRAC_BITS,
  localparam int AW = 34 - G,
  localparam int KPW = 52 - G - F,
  localparam int RW = F + 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    b_valid,
  input  wire logic [RW-1:0]           b_q,
  input  wire logic [2:0][FIELD_W-1:0] b_nv,
  input  wire logic [2:0][AW-1:0]      b_a,
  input  wire logic [KPW-1:0]          b_kp,
  input  wire logic [2:0][FIELD_W-1:0] b_refl,
  input  wire logic                    b_tir,
  output logic                         out_valid,
  output out_t                         out_data
);

  localparam int KW = ((KPW > RW + 1) ? KPW : RW + 1) + 1;
  localparam int KNW = KW + FIELD_W;
  localparam int KNW1 = KNW + 1;

  logic [2:0] v_r;
  logic signed [KW-1:0] k1_r;
  logic [2:0][FIELD_W-1:0] nv1_r, refl1_r, refl2_r;
  logic [2:0][AW-1:0] a1_r, a2_r;
  logic tir1_r, tir2_r;
  logic signed [KNW-1:0] kn2_r [3];
  out_t out_r;

  logic signed [KNW1-1:0] b_t [3];
  logic [FIELD_W-1:0] refr_w [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b_t[i] = (KNW1'(kn2_r[i]) + (KNW1'(1) <<< (F - 1))) >>> F;
      refr_w[i] = tir2_r ? '0 :
                  sat_out(64'($signed(a2_r[i])) - 64'(b_t[i]), F);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], b_valid};
    end
    k1_r <= KW'($signed(b_kp)) + KW'($signed({1'b0, b_q}));
    nv1_r <= b_nv;
    a1_r <= b_a;
    refl1_r <= b_refl;
    tir1_r <= b_tir;
    for (int i = 0; i < 3; i++) begin
      kn2_r[i] <= KNW'(k1_r) * KNW'($signed(nv1_r[i]));
    end
    a2_r <= a1_r;
    refl2_r <= refl1_r;
    tir2_r <= tir1_r;
    out_r.refr_x <= refr_w[0];
    out_r.refr_y <= refr_w[1];
    out_r.refr_z <= refr_w[2];
    out_r.refl_x <= refl2_r[0];
    out_r.refl_y <= refl2_r[1];
    out_r.refl_z <= refl2_r[2];
    out_r.total_reflection <= tir2_r;
  end

  assign out_valid = v_r[2];
  assign out_data = out_r;

endmodule
`default_nettype wire

[design/ray_refract_reflect.sv]
`default_nettype none
// Refraction and mirror reflection of a unit ray at a surface, fully
// pipelined: one item may start in every cycle and busy never rises. Each
// result appears on out_data with out_valid high for exactly one cycle;
// the square root stage computes one root bit per register stage.
// The result cannot be held off, so capture it in the cycle it is shown.
module ray_refract_reflect import rrr_pkg::*; #(
  parameter int COMP_FRAC_BITS = COMP_FRAC_BITS_DEF,
  parameter int INDEX_FRAC_BITS = INDEX_FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  localparam int F = COMP_FRAC_BITS;
  localparam int G = INDEX_FRAC_BITS;
  localparam int AW = 34 - G;
  localparam int KPW = 52 - G - F;
  localparam int RW = F + 1;
  localparam int XW = 2 * F + 2;
  localparam int SW = 6 * FIELD_W + 3 * AW + KPW + 1;
  localparam int LAT = 6 + RW + 1 + 3;

  logic f_valid, f_tir, s_valid;
  logic [XW-1:0] f_x;
  logic [2:0][FIELD_W-1:0] f_nv, f_refl, s_nv, s_refl;
  logic [2:0][AW-1:0] f_a, s_a;
  logic [KPW-1:0] f_kp, s_kp;
  logic s_tir;
  logic [RW-1:0] s_q;
  logic [SW-1:0] s_side;

  assign busy = 1'b0;

  rrr_front #(
    .COMP_FRAC_BITS(COMP_FRAC_BITS),
    .INDEX_FRAC_BITS(INDEX_FRAC_BITS)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(start && !busy), .in_data(in_data),
    .f_valid(f_valid), .f_x(f_x), .f_nv(f_nv), .f_a(f_a), .f_kp(f_kp),
    .f_refl(f_refl), .f_tir(f_tir)
  );

  rrr_sqrt #(.RW(RW), .SW(SW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_x(f_x),
    .in_side({f_nv, f_a, f_kp, f_refl, f_tir}),
    .out_valid(s_valid), .out_root(s_q), .out_side(s_side)
  );

  assign {s_nv, s_a, s_kp, s_refl, s_tir} = s_side;

  rrr_back #(
    .COMP_FRAC_BITS(COMP_FRAC_BITS),
    .INDEX_FRAC_BITS(INDEX_FRAC_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .b_valid(s_valid), .b_q(s_q), .b_nv(s_nv),
    .b_a(s_a), .b_kp(s_kp), .b_refl(s_refl), .b_tir(s_tir),
    .out_valid(out_valid), .out_data(out_data)
  );

`ifndef SYNTHESIS
  a_tir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.total_reflection |->
      out_data.refr_x == '0 && out_data.refr_y == '0 && out_data.refr_z == '0)
    else $error("refracted output not zero on total reflection");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(start && rst_n, LAT))
    else $error("result strobe does not match item start");

  a_stage_count: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid |-> $past(f_valid, RW + 1))
    else $error("root stage produced an item that never entered it");
`endif

endmodule
`default_nettype wire

[tb/tb_ray_refract_reflect.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_ray_refract_reflect;
  import rrr_pkg::*;

  localparam int CF = COMP_FRAC_BITS_DEF;
  localparam int IF = INDEX_FRAC_BITS_DEF;
  localparam int LATENCY = CF + 11;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;

  out_t expected_rays[$];
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int tir_seen = 0;
  int idle_cycles = 0;
  bit allow_gaps = 1'b1;

  ray_refract_reflect uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint round_shift(longint v, int sh);
    longint t;
    if (sh == 0) return v;
    t = v + (longint'(1) << (sh - 1));
    return t >>> sh;
  endfunction

  function automatic longint root_nearest(longint x);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= x) r++;
    if (x - r * r > r) r++;
    return r;
  endfunction

  function automatic logic [15:0] clamp_unit(longint v);
    longint lim;
    lim = longint'(1) << CF;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[15:0];
  endfunction

  function automatic out_t trace_surface(in_t r);
    out_t o;
    longint d[3], nv[3];
    longint n, dot, c, om2, om, s, q, k;
    bit tir;
    d[0] = longint'(r.dir_x); d[1] = longint'(r.dir_y); d[2] = longint'(r.dir_z);
    nv[0] = longint'(r.norm_x); nv[1] = longint'(r.norm_y); nv[2] = longint'(r.norm_z);
    n = longint'({48'd0, r.index_ratio});
    dot = 0;
    for (int i = 0; i < 3; i++) dot += d[i] * nv[i];
    c = round_shift(dot, CF);
    om2 = (longint'(1) << (2 * CF)) - c * c;
    if (om2 < 0) om2 = 0;
    om = round_shift(om2, CF);
    if (om > (longint'(1) << CF)) om = longint'(1) << CF;
    s = round_shift(n * n * om, 2 * IF);
    tir = s > (longint'(1) << CF);
    o = '0;
    o.total_reflection = tir;
    if (!tir) begin
      q = root_nearest(((longint'(1) << CF) - s) << CF);
      k = round_shift(n * dot, IF + CF) + q;
      o.refr_x = clamp_unit(round_shift(n * d[0], IF) - round_shift(k * nv[0], CF));
      o.refr_y = clamp_unit(round_shift(n * d[1], IF) - round_shift(k * nv[1], CF));
      o.refr_z = clamp_unit(round_shift(n * d[2], IF) - round_shift(k * nv[2], CF));
    end
    o.refl_x = clamp_unit(d[0] - round_shift(2 * dot * nv[0], 2 * CF));
    o.refl_y = clamp_unit(d[1] - round_shift(2 * dot * nv[1], 2 * CF));
    o.refl_z = clamp_unit(d[2] - round_shift(2 * dot * nv[2], 2 * CF));
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst_n && start && !busy) idle_cycles <= 0;
    else if (rst_n && out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d results outstanding", expected_rays.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_t exp_ray;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_data.total_reflection) tir_seen++;
      if (expected_rays.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        exp_ray = expected_rays.pop_front();
        if (out_data !== exp_ray) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp refr %0d %0d %0d refl %0d %0d %0d tir %0b | got refr %0d %0d %0d refl %0d %0d %0d tir %0b",
                     exp_ray.refr_x, exp_ray.refr_y, exp_ray.refr_z, exp_ray.refl_x,
                     exp_ray.refl_y, exp_ray.refl_z, exp_ray.total_reflection,
                     out_data.refr_x, out_data.refr_y, out_data.refr_z, out_data.refl_x,
                     out_data.refl_y, out_data.refl_z, out_data.total_reflection);
        end
      end
    end
  end

  task automatic send_ray(in_t r);
    int gap;
    if (allow_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_rays.push_back(trace_surface(r));
    items_sent++;
  endtask

  task automatic go_idle();
    start <= 1'b0;
    in_data <= '0;
    @(posedge clk);
  endtask

  task automatic drain();
    go_idle();
    while (expected_rays.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic in_t make_ray(int dx, int dy, int dz, int nx, int ny, int nz,
                                   int n);
    in_t r;
    r.dir_x = 16'(dx); r.dir_y = 16'(dy); r.dir_z = 16'(dz);
    r.norm_x = 16'(nx); r.norm_y = 16'(ny); r.norm_z = 16'(nz);
    r.index_ratio = 16'(n);
    return r;
  endfunction

  // unit-ish vector built from random angles, quantized to 14 fraction bits
  function automatic void unit_vec(output int x, output int y, output int z);
    real th, ph;
    th = $urandom_range(0, 62831) / 10000.0;
    ph = $urandom_range(0, 31415) / 10000.0;
    x = $rtoi($floor(16384.0 * $sin(ph) * $cos(th) + 0.5));
    y = $rtoi($floor(16384.0 * $sin(ph) * $sin(th) + 0.5));
    z = $rtoi($floor(16384.0 * $cos(ph) + 0.5));
  endfunction

  task automatic test_directed();
    send_ray(make_ray(0, 0, -16384, 0, 0, 16384, 4096));
    send_ray(make_ray(16384, 0, 0, 0, 16384, 0, 4096));
    send_ray(make_ray(11585, 0, -11585, 0, 0, 16384, 6144));
    send_ray(make_ray(11585, 0, -11585, 0, 0, 16384, 2731));
    send_ray(make_ray(11585, -11585, 0, 0, 16384, 0, 0));
    send_ray(make_ray(0, 0, 16384, 0, 0, 16384, 4096));
    send_ray(make_ray(-16384, -16384, -16384, -16384, -16384, -16384, 65535));
    send_ray(make_ray(16384, 16384, 16384, 16384, 16384, 16384, 65535));
    send_ray(make_ray(16384, -16384, 16384, -16384, 16384, -16384, 1));
    send_ray(make_ray(0, 0, 0, 0, 0, 0, 65535));
    send_ray(make_ray(0, 0, 0, 0, 0, 0, 0));
    send_ray(make_ray(-16384, 0, 0, 16384, 0, 0, 32768));
    send_ray(make_ray(8192, 8192, 8192, 0, 0, 16384, 4096));
    send_ray(make_ray(13000, 9000, 3000, 2000, -9000, 13500, 5000));
    send_ray(make_ray(-1, 1, -1, 1, -1, 1, 32767));
    drain();
  endtask

  task automatic test_physical(int count);
    int dx, dy, dz, nx, ny, nz;
    in_t r;
    for (int i = 0; i < count; i++) begin
      unit_vec(dx, dy, dz);
      unit_vec(nx, ny, nz);
      r = make_ray(dx, dy, dz, nx, ny, nz,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(2048, 8192));
      send_ray(r);
    end
  endtask

  task automatic test_raw(int count);
    in_t r;
    for (int i = 0; i < count; i++) begin
      r.dir_x = rand_comp(); r.dir_y = rand_comp(); r.dir_z = rand_comp();
      r.norm_x = rand_comp(); r.norm_y = rand_comp(); r.norm_z = rand_comp();
      r.index_ratio = 16'($urandom_range(0, 65535));
      send_ray(r);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_physical(300);
    drain();
    test_raw(150);
    allow_gaps = 1'b0;
    test_physical(150);
    drain();
    repeat (LATENCY + 5) @(posedge clk);
    $display("sent %0d rays, checked %0d results, %0d with total reflection",
             items_sent, results_seen, tir_seen);
    if (mismatches == 0 && expected_rays.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d missing", mismatches, expected_rays.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
design/rrr_pkg.sv
design/rrr_front.sv
design/rrr_sqrt.sv
design/rrr_back.sv
design/ray_refract_reflect.sv
tb/tb_ray_refract_reflect.sv
